[rtl/core/u32da_pkg.sv]
// ----------------------------------------------------------------------------
// u32da_pkg
// Shared constants and controller/datapath types for the decimal ASCII core.
// ----------------------------------------------------------------------------
package u32da_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 10;

  localparam int DIGIT_W   = 4;
  localparam int BCD_W     = DIGIT_W * MAX_DIGITS;
  localparam int BIT_CNT_W = $clog2(VALUE_BITS);
  localparam int IDX_W     = $clog2(MAX_DIGITS);
  localparam int CHAR_W    = 6;
  localparam int COUNT_W   = 4;
  localparam int IN_W      = 32;

  // ascii '0' within the 6-bit character field
  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);

  localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_BITS - 1);

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a new value, clear bcd register
    logic shift;  // one double dabble step
    logic xfer;   // move converted digits into the emit store
    logic pop;    // one digit taken by the receiver
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bit_last;  // final double dabble step in progress
    logic idx_zero;  // emit pointer on least significant digit
  } dp_status_t;

endpackage

[rtl/core/u32da_if.sv]
// ----------------------------------------------------------------------------
// u32da_value_if / u32da_digit_if
// Valid/ready channels for the input value and the digit results.
// ----------------------------------------------------------------------------
interface u32da_value_if;
  logic                       valid;
  logic                       ready;
  logic [u32da_pkg::IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface u32da_digit_if;
  logic                          valid;
  logic                          ready;
  logic [u32da_pkg::CHAR_W-1:0]  digit_char;
  logic [u32da_pkg::COUNT_W-1:0] digit_count;
  logic                          last;

  modport source (output valid, output digit_char, output digit_count, output last,
                  input ready);
  modport sink   (input valid, input digit_char, input digit_count, input last,
                  output ready);
endinterface

[rtl/core/u32_to_decimal_ascii_core.sv]
// ----------------------------------------------------------------------------
// u32_to_decimal_ascii_core
// Unsigned 32-bit binary to decimal ascii digit stream.
// ----------------------------------------------------------------------------
// usage
//   number : valid/ready channel, one 32-bit unsigned value per transaction
//   digits : valid/ready channel, one ascii digit per transaction, most
//            significant first, leading zeros dropped (zero gives one '0');
//            every digit carries the total digit count, last flags the final
//   a value is converted by bit-serial double dabble, one bit per cycle, then
//   moved into a digit store; the first digit is offered once it is loaded
//   the serial shift loop takes a new value as the last moves to the store;
//   digits of one value drain from the store while the next value converts
//   when the receiver stalls, the digit store holds and the finished
//   conversion waits; number.ready stays low until the store frees
//   reset (rst, synchronous) idles the sequencer and clears the output
//   valid; the digit store itself is not cleared
// ----------------------------------------------------------------------------
module u32_to_decimal_ascii_core (
  input logic          clk,
  input logic          rst,
  u32da_value_if.sink  number,
  u32da_digit_if.source digits
);
  import u32da_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: conversion steps, store transfer, emit handshake
  u32da_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (digits.valid),
    .out_ready (digits.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // shift register, bcd register, digit store and ascii output
  u32da_dp u_dp (
    .clk         (clk),
    .value       (number.value),
    .cmd         (cmd),
    .status      (status),
    .digit_char  (digits.digit_char),
    .digit_count (digits.digit_count),
    .last        (digits.last)
  );

endmodule

[rtl/core/u32da_ctrl.sv]
// ----------------------------------------------------------------------------
// u32da_ctrl
// Conversion sequencer and emit handshake control.
// ----------------------------------------------------------------------------
module u32da_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output u32da_pkg::ctrl_cmd_t  cmd,
  input  u32da_pkg::dp_status_t status
);
  import u32da_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       emit_busy;
  logic       emit_busy_next;
  logic       store_free;

  assign out_valid  = emit_busy;
  assign store_free = !emit_busy || (out_ready && status.idx_zero);

  always_comb begin
    cmd.xfer  = (state == ST_DONE) && store_free;
    cmd.shift = (state == ST_SHIFT);
    cmd.pop   = emit_busy && out_ready;
    in_ready  = (state == ST_IDLE) || cmd.xfer;
    cmd.load  = in_valid && in_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (status.bit_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (cmd.xfer) state_next = cmd.load ? ST_SHIFT : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_busy_next = emit_busy;
    priority if (cmd.xfer) begin
      emit_busy_next = 1'b1;
    end else if (cmd.pop && status.idx_zero) begin
      emit_busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      emit_busy <= 1'b0;
    end else begin
      state     <= state_next;
      emit_busy <= emit_busy_next;
    end
  end

endmodule

[rtl/core/u32da_dp.sv]
// ----------------------------------------------------------------------------
// u32da_dp
// Bit-serial double dabble converter, digit store and ascii output mux.
// ----------------------------------------------------------------------------
module u32da_dp (
  input  logic                          clk,
  input  logic [u32da_pkg::IN_W-1:0]    value,
  input  u32da_pkg::ctrl_cmd_t          cmd,
  output u32da_pkg::dp_status_t         status,
  output logic [u32da_pkg::CHAR_W-1:0]  digit_char,
  output logic [u32da_pkg::COUNT_W-1:0] digit_count,
  output logic                          last
);
  import u32da_pkg::*;

  logic [VALUE_BITS-1:0] shreg;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic                  ovf;

  logic [DIGIT_W-1:0]    store [MAX_DIGITS];
  logic [COUNT_W-1:0]    stored_count;
  logic [IDX_W-1:0]      emit_index;

  logic [IDX_W-1:0]      top_calc;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // position of the most significant nonzero digit; full width on overflow
  always_comb begin
    top_calc = '0;
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) top_calc = IDX_W'(i);
    end
    if (ovf) top_calc = IDX_W'(MAX_DIGITS - 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg   <= value[VALUE_BITS-1:0];
      bcd     <= '0;
      bit_cnt <= '0;
      ovf     <= 1'b0;
    end else if (cmd.shift) begin
      shreg   <= {shreg[VALUE_BITS-2:0], 1'b0};
      bcd     <= {bcd_adj[BCD_W-2:0], shreg[VALUE_BITS-1]};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      ovf     <= ovf | bcd_adj[BCD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.xfer) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        store[i] <= bcd[i*DIGIT_W +: DIGIT_W];
      end
      stored_count <= COUNT_W'(int'(top_calc) + 1);
      emit_index   <= top_calc;
    end else if (cmd.pop && (emit_index != '0)) begin
      emit_index <= emit_index - IDX_W'(1);
    end
  end

  assign status.bit_last = (bit_cnt == BIT_LAST);
  assign status.idx_zero = (emit_index == '0);

  assign digit_char  = CHAR_ZERO + CHAR_W'(store[emit_index]);
  assign digit_count = stored_count;
  assign last        = (emit_index == '0);

endmodule
